### src/hcd_pkg.sv
// Package for the chunked body decoder: parse phases, status codes, result type
// and the size-line digit helpers. It has no dependencies.
`default_nettype none

package hcd_pkg;

  // Width of the chunk size accumulator and the chunk byte counter.
  localparam int SIZE_BITS = 32;
  // Width of the length-mode byte counter and of content_length.
  localparam int CNT_BITS  = 32;
  localparam int ADDR_BITS = 3;

  localparam logic [7:0] ASCII_CR     = 8'd13;
  localparam logic [7:0] ASCII_LF     = 8'd10;
  localparam logic [7:0] ASCII_ZERO   = 8'd48;
  localparam logic [7:0] ASCII_NINE   = 8'd57;
  localparam logic [7:0] ASCII_LOW_A  = 8'd97;
  localparam logic [7:0] ASCII_LOW_F  = 8'd102;
  localparam logic [7:0] HEX_LETTER_OFS = 8'd87;

  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Register indexes on the configuration port (address bit 2).
  localparam logic REG_CHUNKED_MODE   = 1'b0;
  localparam logic REG_CONTENT_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP1,
    PH_SKIP2,
    PH_DONE
  } phase_t;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
  } result_t;

  // Value of one size-line byte: 0-9 and a-f count, anything else is zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      v = c - ASCII_ZERO;
    end else if (c >= ASCII_LOW_A && c <= ASCII_LOW_F) begin
      v = c - HEX_LETTER_OFS;
    end
    return v[3:0];
  endfunction

  // Shift one hex digit into the size; saturate when the top nibble is in use.
  function automatic size_t push_digit(input size_t acc, input logic [3:0] d);
    size_t r;
    if (|acc[SIZE_BITS-1 -: 4]) begin
      r = '1;
    end else begin
      r = {acc[SIZE_BITS-5:0], d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/hcd_in_if.sv
// Input channel of the chunked body decoder: valid/ready plus one request.
// No dependencies.
`default_nettype none

interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] body_byte;

  modport source (output valid, req_type, body_byte, input ready);
  modport sink   (input valid, req_type, body_byte, output ready);
endinterface

`default_nettype wire

### src/hcd_out_if.sv
// Result channel of the chunked body decoder: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] status;

  modport source (output valid, payload_valid, payload_byte, status, input ready);
  modport sink   (input valid, payload_valid, payload_byte, status, output ready);
endinterface

`default_nettype wire

### src/hcd_core.sv
// Parse state machine of the chunked body decoder. Updates its state on each
// accepted item and presents that item's result combinationally. Uses hcd_pkg.
`default_nettype none

module hcd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             req_type,
  input  wire logic [7:0]       body_byte,
  input  wire logic             chunked_mode,
  input  wire hcd_pkg::cnt_t    content_length,
  output hcd_pkg::result_t      result
);

  hcd_pkg::phase_t phase_r, phase_nxt;
  logic            cr_pending_r, cr_pending_nxt;
  hcd_pkg::size_t  size_acc_r, size_acc_nxt;
  hcd_pkg::size_t  chunk_rem_r, chunk_rem_nxt;
  hcd_pkg::cnt_t   byte_count_r, byte_count_nxt;

  hcd_pkg::size_t  acc_after_cr;
  hcd_pkg::size_t  rem_dec;
  hcd_pkg::cnt_t   count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hcd_pkg::PH_SIZE;
      cr_pending_r <= 1'b0;
      size_acc_r   <= '0;
      chunk_rem_r  <= '0;
      byte_count_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      cr_pending_r <= cr_pending_nxt;
      size_acc_r   <= size_acc_nxt;
      chunk_rem_r  <= chunk_rem_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  always_comb begin
    // A CR that is not followed by LF counts as a zero digit.
    acc_after_cr = cr_pending_r ? hcd_pkg::push_digit(size_acc_r, 4'd0) : size_acc_r;
    rem_dec      = (chunk_rem_r != '0) ? chunk_rem_r - 1'b1 : chunk_rem_r;
    count_inc    = (byte_count_r != '1) ? byte_count_r + 1'b1 : byte_count_r;

    phase_nxt      = phase_r;
    cr_pending_nxt = cr_pending_r;
    size_acc_nxt   = size_acc_r;
    chunk_rem_nxt  = chunk_rem_r;
    byte_count_nxt = byte_count_r;
    result         = '0;

    if (accept) begin
      if (req_type == hcd_pkg::REQ_BEGIN) begin
        phase_nxt      = hcd_pkg::PH_SIZE;
        cr_pending_nxt = 1'b0;
        size_acc_nxt   = '0;
        chunk_rem_nxt  = '0;
        byte_count_nxt = '0;
        if (!chunked_mode && content_length == '0) begin
          phase_nxt     = hcd_pkg::PH_DONE;
          result.status = hcd_pkg::ST_COMPLETE;
        end
      end else if (phase_r == hcd_pkg::PH_DONE) begin
        result.status = hcd_pkg::ST_DROPPED;
      end else if (!chunked_mode) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = body_byte;
        byte_count_nxt       = count_inc;
        if (count_inc >= content_length) begin
          phase_nxt     = hcd_pkg::PH_DONE;
          result.status = hcd_pkg::ST_COMPLETE;
        end
      end else begin
        case (phase_r)
          hcd_pkg::PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = body_byte;
            chunk_rem_nxt        = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt = hcd_pkg::PH_SKIP1;
            end
          end
          hcd_pkg::PH_SKIP1: begin
            phase_nxt = hcd_pkg::PH_SKIP2;
          end
          hcd_pkg::PH_SKIP2: begin
            phase_nxt      = hcd_pkg::PH_SIZE;
            cr_pending_nxt = 1'b0;
            size_acc_nxt   = '0;
          end
          hcd_pkg::PH_SIZE: begin
            if (cr_pending_r && body_byte == hcd_pkg::ASCII_LF) begin
              cr_pending_nxt = 1'b0;
              size_acc_nxt   = '0;
              if (size_acc_r == '0) begin
                phase_nxt     = hcd_pkg::PH_DONE;
                result.status = hcd_pkg::ST_COMPLETE;
              end else begin
                chunk_rem_nxt = size_acc_r;
                phase_nxt     = hcd_pkg::PH_DATA;
              end
            end else if (body_byte == hcd_pkg::ASCII_CR) begin
              cr_pending_nxt = 1'b1;
              size_acc_nxt   = acc_after_cr;
            end else begin
              cr_pending_nxt = 1'b0;
              size_acc_nxt   = hcd_pkg::push_digit(acc_after_cr,
                                                   hcd_pkg::hex_digit(body_byte));
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### src/hcd_out_buf.sv
// Two-entry result buffer (output register plus skid stage) for the chunked
// body decoder. Uses hcd_pkg and hcd_out_if.
`default_nettype none

module hcd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hcd_pkg::result_t  push_data,
  output logic                   can_push,
  hcd_out_if.source              out_ch
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  hcd_pkg::result_t out_r, out_nxt;
  hcd_pkg::result_t skid_r, skid_nxt;
  logic             out_free;

  assign can_push            = !skid_v_r;
  assign out_free            = !out_v_r || out_ch.ready;
  assign out_ch.valid         = out_v_r;
  assign out_ch.payload_valid = out_r.payload_valid;
  assign out_ch.payload_byte  = out_r.payload_byte;
  assign out_ch.status        = out_r.status;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

### src/http_body_chunked_decoder_top.sv
// Top level of the HTTP message body decoder (chunked or content-length).
// Depends on hcd_pkg, hcd_in_if, hcd_out_if, hcd_core and hcd_out_buf.
`default_nettype none

// The block takes HTTP body bytes, one per transfer on in_ch, and returns
// exactly one result per input transfer on out_ch. A begin request (req_type 0)
// restarts parsing. With chunked_mode set, each chunk's hexadecimal size line
// up to CR LF is parsed (0-9 and a-f count, any other byte counts as a zero
// digit, the size saturates at all ones), then that many bytes are passed on
// with payload_valid set, the two bytes after them are skipped, and a size of
// zero completes the body. With chunked_mode clear, bytes are passed on until
// their count reaches content_length. Status reports completion on the item
// that ends the body and marks bytes dropped after it. The decoder accepts one
// item every clock cycle while in_ch.ready is high: all parsing for a byte is a
// single state update; each result is registered in the output or skid stage.
// A skid stage behind the output register keeps the input side accepting while
// one result waits, so in_ch.ready drops only when two results are held.
// Registers are written over the APB-style port: chunked_mode at address 0 and
// content_length at address 4; they should change only while the block is idle.

module http_body_chunked_decoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hcd_in_if.sink                             in_ch,
  hcd_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hcd_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  logic             chunked_mode_r;
  hcd_pkg::cnt_t    content_length_r;
  logic             cfg_write;
  logic             in_accept;
  logic             buf_can_push;
  hcd_pkg::result_t core_result;

  // Configuration registers. Address bit 2 selects the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r   <= 1'b0;
      content_length_r <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        hcd_pkg::REG_CHUNKED_MODE:   chunked_mode_r   <= pwdata[0];
        hcd_pkg::REG_CONTENT_LENGTH: content_length_r <= pwdata[hcd_pkg::CNT_BITS-1:0];
        default:                     chunked_mode_r   <= chunked_mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      hcd_pkg::REG_CHUNKED_MODE:   prdata = {31'd0, chunked_mode_r};
      hcd_pkg::REG_CONTENT_LENGTH: prdata = content_length_r;
      default:                     prdata = '0;
    endcase
  end

  // An item is taken whenever the result buffer has room for its result.
  assign in_ch.ready = buf_can_push;
  assign in_accept   = in_ch.valid && buf_can_push;

  hcd_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .req_type       (in_ch.req_type),
    .body_byte      (in_ch.body_byte),
    .chunked_mode   (chunked_mode_r),
    .content_length (content_length_r),
    .result         (core_result)
  );

  hcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_result),
    .can_push  (buf_can_push),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
